// ===== rtl/hashed_jump_target_cache_assert.svh =====
// Assertion macros shared by the jump target cache modules.
`ifndef HASHED_JUMP_TARGET_CACHE_ASSERT_SVH
`define HASHED_JUMP_TARGET_CACHE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define HJTC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define HJTC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hjtc_pkg.sv =====
// Shared types, constants and helpers of the hashed jump target cache.
package hjtc_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;

  localparam int CMD_W    = 2;
  localparam int TAG_W    = 64;
  localparam int HANDLE_W = 48;
  localparam int COUNT_W  = 32;

  // Murmur3 64-bit finalizer constants
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // One table slot as stored in memory
  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  hits;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    CS_INIT,
    CS_IDLE,
    CS_HASH,
    CS_LOOK,
    CS_SWEEP,
    CS_RESP
  } ctl_state_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_MUL,
    HS_RED
  } hash_state_t;

  // Saturating increment of a 32-bit counter
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/hjtc_ram.sv =====
// Generic single-port-write, registered-read RAM.
module hjtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/hjtc_hash.sv =====
// Iterative Murmur3 fmix64 hash with slot reduction over one shared 32x32 multiplier.
`include "hashed_jump_target_cache_assert.svh"

module hjtc_hash import hjtc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TAG_W-1:0] key,
  output logic             done,
  output logic [IDX_W-1:0] index
);

  localparam bit               IS_POW2   = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  // Reduce one byte of the hash per step: value = {remainder, byte}
  localparam int               VAL_W     = IDX_W + 8;
  localparam int               RED_SHIFT = 2 * IDX_W + 8;
  localparam logic [63:0]      RECIP     = (64'd1 << RED_SHIFT) / 64'(TABLE_ENTRIES);
  localparam logic [VAL_W-1:0] N_VAL     = VAL_W'(TABLE_ENTRIES);
  localparam logic [31:0]      N_32      = 32'(TABLE_ENTRIES);

  hash_state_t      state, state_next;
  logic [1:0]       step;
  logic             round;
  logic             phase;
  logic [2:0]       chunk;
  logic [63:0]      x;
  logic [63:0]      acc;
  logic [IDX_W-1:0] rem;
  logic [VAL_W-1:0] val;
  logic [7:0]       quot;

  logic [63:0]      cst;
  logic [VAL_W-1:0] val_cat;
  logic [31:0]      mul_a;
  logic [31:0]      mul_c;
  logic [63:0]      prod;
  logic [31:0]      acc_hi_sum;
  logic [63:0]      mixed;
  logic [63:0]      x_fold;
  logic [VAL_W-1:0] diff;
  logic [IDX_W-1:0] rem_next;
  logic             last_mul;
  logic             last_red;

  // Select the multiplier operands: lo*lo, lo*hi, hi*lo while mixing,
  // value*reciprocal or quotient*entries while reducing
  always_comb begin
    cst     = round ? MIX_C2 : MIX_C1;
    val_cat = {rem, x[63:56]};
    if (state == HS_RED) begin
      mul_a = phase ? 32'(quot) : 32'(val_cat);
      mul_c = phase ? N_32 : RECIP[31:0];
    end else begin
      mul_a = (step == 2'd2) ? x[63:32] : x[31:0];
      mul_c = (step == 2'd1) ? cst[63:32] : cst[31:0];
    end
    prod       = 64'(mul_a) * 64'(mul_c);
    acc_hi_sum = acc[63:32] + prod[31:0];
    mixed      = {acc_hi_sum, acc[31:0]};
    x_fold     = mixed ^ (mixed >> MIX_SHIFT);
  end

  // Subtract the quotient estimate, then correct by at most one more entries count
  always_comb begin
    diff     = val - prod[VAL_W-1:0];
    rem_next = (diff >= N_VAL) ? IDX_W'(diff - N_VAL) : diff[IDX_W-1:0];
  end

  assign last_mul = (state == HS_MUL) && (step == 2'd2) && round;
  assign last_red = (state == HS_RED) && phase && (chunk == 3'd7);

  // State register and sequencing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HS_IDLE;
      step  <= 2'd0;
      round <= 1'b0;
      phase <= 1'b0;
      chunk <= 3'd0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (last_mul && IS_POW2) || last_red;
      if (state == HS_IDLE && start) begin
        step  <= 2'd0;
        round <= 1'b0;
      end else if (state == HS_MUL) begin
        if (step == 2'd2) begin
          step  <= 2'd0;
          round <= 1'b1;
          phase <= 1'b0;
          chunk <= 3'd0;
        end else begin
          step <= step + 2'd1;
        end
      end else if (state == HS_RED) begin
        phase <= ~phase;
        if (phase) begin
          chunk <= chunk + 3'd1;
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      HS_IDLE: begin
        if (start) begin
          state_next = HS_MUL;
        end
      end
      HS_MUL: begin
        if (last_mul) begin
          state_next = IS_POW2 ? HS_IDLE : HS_RED;
        end
      end
      HS_RED: begin
        if (last_red) begin
          state_next = HS_IDLE;
        end
      end
      default: state_next = HS_IDLE;
    endcase
  end

  // Datapath: fold, accumulate partial products, reduce the hash a byte at a time
  always_ff @(posedge clk) begin
    if (state == HS_IDLE && start) begin
      x <= key ^ (key >> MIX_SHIFT);
    end else if (state == HS_MUL) begin
      unique case (step)
        2'd0: acc <= prod;
        2'd1: acc[63:32] <= acc_hi_sum;
        2'd2: begin
          x   <= x_fold;
          rem <= '0;
          if (round) begin
            index <= x_fold[IDX_W-1:0];
          end
        end
        default: acc <= acc;
      endcase
    end else if (state == HS_RED) begin
      if (!phase) begin
        val  <= val_cat;
        quot <= prod[RED_SHIFT +: 8];
        x    <= x << 8;
      end else begin
        rem <= rem_next;
        if (chunk == 3'd7) begin
          index <= rem_next;
        end
      end
    end
  end

  `HJTC_ASSERT_NOW(a_start_idle, start, state == HS_IDLE, "hash started while busy")
  `HJTC_ASSERT_NEXT(a_done_idle, done, state == HS_IDLE, "hash not idle after done")
  `HJTC_ASSERT_NOW(a_step_range, state == HS_MUL, step != 2'd3, "multiply step out of range")

endmodule

// ===== rtl/hashed_jump_target_cache.sv =====
// Top level: direct-mapped jump target cache with hashed slot index.
//
//  channel | valid     | ready     | beat fields
//  --------+-----------+-----------+-------------------------------------------
//  cmd     | cmd_valid | cmd_ready | command, jump_pc, code_handle
//  rsp     | rsp_valid | rsp_ready | hit, code_out, entry_hit_count,
//          |           |           | total_hit_count, total_miss_count
//
// Lookup, add and unused commands pass through six steps of the shared
// 32x32 multiplier, then, for a table that is not a power of two, eight byte
// reduction steps, then one RAM read and one write-back on the edge that
// loads the response.
// Clear sweeps the slot RAM one entry a cycle.
// After reset the same sweep runs over every entry with cmd_ready low.
// One command is in flight at a time; the next is accepted while its response
// waits in the output register, and write-back stalls until that register frees.
`include "hashed_jump_target_cache_assert.svh"

module hashed_jump_target_cache import hjtc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [TAG_W-1:0]    jump_pc,
  input  logic [HANDLE_W-1:0] code_handle,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic                hit,
  output logic [HANDLE_W-1:0] code_out,
  output logic [COUNT_W-1:0]  entry_hit_count,
  output logic [COUNT_W-1:0]  total_hit_count,
  output logic [COUNT_W-1:0]  total_miss_count
);

  localparam int               IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(TABLE_ENTRIES - 1);

  ctl_state_t          state, state_next;
  logic [IDX_W-1:0]    sweep_addr;
  logic [CMD_W-1:0]    item_cmd;
  logic [TAG_W-1:0]    item_pc;
  logic [HANDLE_W-1:0] item_handle;
  logic [COUNT_W-1:0]  hit_sum, hit_sum_next;
  logic [COUNT_W-1:0]  miss_sum, miss_sum_next;

  logic                accept;
  logic                hash_start;
  logic                hash_done;
  logic [IDX_W-1:0]    hash_index;
  logic                out_free;
  logic                rd_en;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;
  entry_t              rd_data;
  logic [ENTRY_W-1:0]  rd_bits;
  logic                sweep_on;
  logic                sweep_last;
  logic                rsp_load;
  logic                hit_next;
  logic [HANDLE_W-1:0] code_next;
  logic [COUNT_W-1:0]  entry_next;
  logic                match;

  assign accept     = cmd_valid && cmd_ready;
  assign hash_start = accept && (command != CMD_CLEAR);
  assign out_free   = !rsp_valid || rsp_ready;
  assign rd_data    = entry_t'(rd_bits);
  assign match      = (rd_data.tag == item_pc) && (rd_data.handle != '0);
  assign sweep_last = (sweep_addr == LAST);

  hjtc_hash #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_hash (
    .clk  (clk),
    .rst  (rst),
    .start(hash_start),
    .key  (jump_pc),
    .done (hash_done),
    .index(hash_index)
  );

  hjtc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_slots (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(hash_index),
    .rdata(rd_bits)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory control and response values
  always_comb begin
    state_next    = state;
    cmd_ready     = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = hash_index;
    wr_data       = '0;
    sweep_on      = 1'b0;
    rsp_load      = 1'b0;
    hit_next      = 1'b0;
    code_next     = '0;
    entry_next    = '0;
    hit_sum_next  = hit_sum;
    miss_sum_next = miss_sum;
    unique case (state)
      CS_INIT, CS_SWEEP: begin
        sweep_on = 1'b1;
        wr_en    = 1'b1;
        wr_addr  = sweep_addr;
        if (sweep_last) begin
          state_next = (state == CS_INIT) ? CS_IDLE : CS_RESP;
        end
      end
      CS_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next = (command == CMD_CLEAR) ? CS_SWEEP : CS_HASH;
        end
      end
      CS_HASH: begin
        if (hash_done) begin
          rd_en      = 1'b1;
          state_next = CS_LOOK;
        end
      end
      CS_LOOK: begin
        entry_next = rd_data.hits;
        unique case (item_cmd)
          CMD_LOOKUP: begin
            if (match) begin
              hit_next     = 1'b1;
              code_next    = rd_data.handle;
              entry_next   = sat_inc(rd_data.hits);
              wr_data      = rd_data;
              wr_data.hits = entry_next;
              wr_en        = out_free;
              hit_sum_next = sat_inc(hit_sum);
            end else begin
              miss_sum_next = sat_inc(miss_sum);
            end
          end
          CMD_ADD: begin
            entry_next     = '0;
            wr_data.tag    = item_pc;
            wr_data.handle = item_handle;
            wr_en          = out_free;
          end
          default: entry_next = rd_data.hits;
        endcase
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = CS_IDLE;
        end
      end
      CS_RESP: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // Sweep address, totals and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      hit_sum    <= '0;
      miss_sum   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (sweep_on) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      end
      if (rsp_load) begin
        hit_sum   <= hit_sum_next;
        miss_sum  <= miss_sum_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold the accepted command beat
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd    <= command;
      item_pc     <= jump_pc;
      item_handle <= code_handle;
    end
  end

  // Load the response beat
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      hit              <= hit_next;
      code_out         <= code_next;
      entry_hit_count  <= entry_next;
      total_hit_count  <= hit_sum_next;
      total_miss_count <= miss_sum_next;
    end
  end

  `HJTC_ASSERT_NOW(a_done_in_hash, hash_done, state == CS_HASH, "hash result arrived unexpectedly")
  `HJTC_ASSERT_NEXT(a_one_in_flight, accept, !cmd_ready, "second command taken while busy")
  `HJTC_ASSERT_NOW(a_hits_monotonic, !$past(rst), hit_sum >= $past(hit_sum), "hit total fell")
  `HJTC_ASSERT_NOW(a_miss_monotonic, !$past(rst), miss_sum >= $past(miss_sum), "miss total fell")

endmodule
